>>> design/bsa_pkg.sv
// Shared constants for the box surface area pipeline.
package bsa_pkg;

    localparam int OUT_BITS = 37;
    localparam int LANES    = 3;

    typedef logic [OUT_BITS-1:0] t_area;

endpackage

>>> design/bsa_sqrt_cell.sv
// One digit step of the pipelined fixed point square root.
module bsa_sqrt_cell #(
    parameter int RAD_BITS  = 34,
    parameter int ROOT_BITS = 33
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [RAD_BITS-1:0]  i_rad,
    input  logic [ROOT_BITS+2:0] i_rem,
    input  logic [ROOT_BITS-1:0] i_root,
    output logic [RAD_BITS-1:0]  o_rad,
    output logic [ROOT_BITS+2:0] o_rem,
    output logic [ROOT_BITS-1:0] o_root
);

    localparam int REM_BITS = ROOT_BITS + 3;

    logic [REM_BITS-1:0]  n_rem_sh;
    logic [REM_BITS-1:0]  n_trial;
    logic [REM_BITS-1:0]  n_rem;
    logic [ROOT_BITS-1:0] n_root;
    logic [RAD_BITS-1:0]  r_rad;
    logic [REM_BITS-1:0]  r_rem;
    logic [ROOT_BITS-1:0] r_root;

    always_comb begin
        n_rem_sh = {i_rem[REM_BITS-3:0], i_rad[RAD_BITS-1:RAD_BITS-2]};
        n_trial  = {1'b0, i_root, 2'b01};
        if (n_rem_sh >= n_trial) begin
            n_rem  = n_rem_sh - n_trial;
            n_root = {i_root[ROOT_BITS-2:0], 1'b1};
        end else begin
            n_rem  = n_rem_sh;
            n_root = {i_root[ROOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= {i_rad[RAD_BITS-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

>>> design/bsa_prod.sv
// Pairwise length products, their sum, scaling and saturation.
module bsa_prod #(
    parameter int ROOT_BITS = 33,
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [ROOT_BITS-1:0] i_len [bsa_pkg::LANES],
    output bsa_pkg::t_area       o_area
);

    localparam int LO_BITS  = (ROOT_BITS + 1) / 2;
    localparam int PP_BITS  = 2 * LO_BITS;
    localparam int PR_BITS  = 2 * ROOT_BITS;
    localparam int SUM_BITS = PR_BITS + 2;
    localparam int SH       = 2 * FRAC_BITS - 1;
    localparam int W_BITS   = (SUM_BITS > bsa_pkg::OUT_BITS + 1) ?
                              SUM_BITS : bsa_pkg::OUT_BITS + 1;

    logic [ROOT_BITS-1:0] n_a [bsa_pkg::LANES];
    logic [ROOT_BITS-1:0] n_b [bsa_pkg::LANES];
    logic [PP_BITS-1:0]   r_ll [bsa_pkg::LANES];
    logic [PP_BITS-1:0]   r_lh [bsa_pkg::LANES];
    logic [PP_BITS-1:0]   r_hl [bsa_pkg::LANES];
    logic [PP_BITS-1:0]   r_hh [bsa_pkg::LANES];
    logic [PR_BITS-1:0]   r_pr [bsa_pkg::LANES];
    logic [SUM_BITS-1:0]  r_sum;
    logic [W_BITS-1:0]    n_shift;
    bsa_pkg::t_area       r_area;

    always_comb begin
        n_a[0] = i_len[0];
        n_b[0] = i_len[1];
        n_a[1] = i_len[0];
        n_b[1] = i_len[2];
        n_a[2] = i_len[1];
        n_b[2] = i_len[2];
        n_shift = W_BITS'(r_sum) >> SH;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int p = 0; p < bsa_pkg::LANES; p++) begin
                r_ll[p] <= PP_BITS'(n_a[p][LO_BITS-1:0]) * PP_BITS'(n_b[p][LO_BITS-1:0]);
                r_lh[p] <= PP_BITS'(n_a[p][LO_BITS-1:0]) *
                           PP_BITS'(n_b[p][ROOT_BITS-1:LO_BITS]);
                r_hl[p] <= PP_BITS'(n_a[p][ROOT_BITS-1:LO_BITS]) *
                           PP_BITS'(n_b[p][LO_BITS-1:0]);
                r_hh[p] <= PP_BITS'(n_a[p][ROOT_BITS-1:LO_BITS]) *
                           PP_BITS'(n_b[p][ROOT_BITS-1:LO_BITS]);
                r_pr[p] <= (PR_BITS'(r_hh[p]) << (2 * LO_BITS))
                         + ((PR_BITS'(r_lh[p]) + PR_BITS'(r_hl[p])) << LO_BITS)
                         + PR_BITS'(r_ll[p]);
            end
            r_sum <= SUM_BITS'(r_pr[0]) + SUM_BITS'(r_pr[1]) + SUM_BITS'(r_pr[2]);
            if ((n_shift >> bsa_pkg::OUT_BITS) != '0) begin
                r_area <= '1;
            end else begin
                r_area <= n_shift[bsa_pkg::OUT_BITS-1:0];
            end
        end
    end

    assign o_area = r_area;

endmodule

>>> design/box_surface_area_from_corners.sv
// Top level: box surface area from four corners, fully pipelined.
//
//  channel  valid    stall    payload
//  input    i_valid  o_stall  i_base_*, i_first_*, i_second_*, i_third_* (x, y, z)
//  output   o_valid  i_stall  o_surface_area
//
// One word is accepted per cycle while the output does not stall. Each word passes the
// coordinate differences, squares, sum of squares, the chain of square root cells (one
// root digit per cell), and the partial products, products, sum and scaled area. A stall
// on the output freezes the whole pipeline. Reset clears only the valid bits.
module box_surface_area_from_corners #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [COORD_BITS-1:0] i_base_x,
    input  logic [COORD_BITS-1:0] i_base_y,
    input  logic [COORD_BITS-1:0] i_base_z,
    input  logic [COORD_BITS-1:0] i_first_x,
    input  logic [COORD_BITS-1:0] i_first_y,
    input  logic [COORD_BITS-1:0] i_first_z,
    input  logic [COORD_BITS-1:0] i_second_x,
    input  logic [COORD_BITS-1:0] i_second_y,
    input  logic [COORD_BITS-1:0] i_second_z,
    input  logic [COORD_BITS-1:0] i_third_x,
    input  logic [COORD_BITS-1:0] i_third_y,
    input  logic [COORD_BITS-1:0] i_third_z,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [bsa_pkg::OUT_BITS-1:0] o_surface_area
);

    localparam int D_BITS    = COORD_BITS + 1;
    localparam int SQ_BITS   = 2 * COORD_BITS + 2;
    localparam int STEPS     = SQ_BITS / 2 + FRAC_BITS;
    localparam int ROOT_BITS = STEPS;
    localparam int TOTAL     = 3 + STEPS + 4;

    logic                      n_en;
    logic [TOTAL-1:0]          r_vld;
    logic signed [D_BITS-1:0]  r_d   [bsa_pkg::LANES][3];
    logic [2*COORD_BITS-1:0]   r_s2  [bsa_pkg::LANES][3];
    logic [SQ_BITS-1:0]        r_sq  [bsa_pkg::LANES];
    logic [D_BITS-1:0]         n_abs [bsa_pkg::LANES][3];
    logic [SQ_BITS-1:0]        w_rad  [bsa_pkg::LANES][STEPS+1];
    logic [ROOT_BITS+2:0]      w_rem  [bsa_pkg::LANES][STEPS+1];
    logic [ROOT_BITS-1:0]      w_root [bsa_pkg::LANES][STEPS+1];
    logic [ROOT_BITS-1:0]      w_len  [bsa_pkg::LANES];

    assign n_en    = !(r_vld[TOTAL-1] && i_stall);
    assign o_stall = !n_en;
    assign o_valid = r_vld[TOTAL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[TOTAL-2:0], i_valid};
        end
    end

    always_comb begin
        for (int l = 0; l < bsa_pkg::LANES; l++) begin
            for (int k = 0; k < 3; k++) begin
                n_abs[l][k] = r_d[l][k][D_BITS-1] ? D_BITS'(-r_d[l][k]) : D_BITS'(r_d[l][k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_d[0][0] <= $signed({i_first_x[COORD_BITS-1], i_first_x})
                       - $signed({i_base_x[COORD_BITS-1], i_base_x});
            r_d[0][1] <= $signed({i_first_y[COORD_BITS-1], i_first_y})
                       - $signed({i_base_y[COORD_BITS-1], i_base_y});
            r_d[0][2] <= $signed({i_first_z[COORD_BITS-1], i_first_z})
                       - $signed({i_base_z[COORD_BITS-1], i_base_z});
            r_d[1][0] <= $signed({i_second_x[COORD_BITS-1], i_second_x})
                       - $signed({i_base_x[COORD_BITS-1], i_base_x});
            r_d[1][1] <= $signed({i_second_y[COORD_BITS-1], i_second_y})
                       - $signed({i_base_y[COORD_BITS-1], i_base_y});
            r_d[1][2] <= $signed({i_second_z[COORD_BITS-1], i_second_z})
                       - $signed({i_base_z[COORD_BITS-1], i_base_z});
            r_d[2][0] <= $signed({i_base_x[COORD_BITS-1], i_base_x})
                       - $signed({i_third_x[COORD_BITS-1], i_third_x});
            r_d[2][1] <= $signed({i_base_y[COORD_BITS-1], i_base_y})
                       - $signed({i_third_y[COORD_BITS-1], i_third_y});
            r_d[2][2] <= $signed({i_base_z[COORD_BITS-1], i_base_z})
                       - $signed({i_third_z[COORD_BITS-1], i_third_z});
            for (int l = 0; l < bsa_pkg::LANES; l++) begin
                for (int k = 0; k < 3; k++) begin
                    r_s2[l][k] <= n_abs[l][k][COORD_BITS-1:0] * n_abs[l][k][COORD_BITS-1:0];
                end
                r_sq[l] <= SQ_BITS'(r_s2[l][0]) + SQ_BITS'(r_s2[l][1])
                         + SQ_BITS'(r_s2[l][2]);
            end
        end
    end

    for (genvar l = 0; l < bsa_pkg::LANES; l++) begin : g_lane
        assign w_rad[l][0]  = r_sq[l];
        assign w_rem[l][0]  = '0;
        assign w_root[l][0] = '0;
        for (genvar s = 0; s < STEPS; s++) begin : g_cell
            bsa_sqrt_cell #(
                .RAD_BITS  (SQ_BITS),
                .ROOT_BITS (ROOT_BITS)
            ) u_cell (
                .i_clk  (i_clk),
                .i_en   (n_en),
                .i_rad  (w_rad[l][s]),
                .i_rem  (w_rem[l][s]),
                .i_root (w_root[l][s]),
                .o_rad  (w_rad[l][s+1]),
                .o_rem  (w_rem[l][s+1]),
                .o_root (w_root[l][s+1])
            );
        end
        assign w_len[l] = w_root[l][STEPS];
    end

    bsa_prod #(
        .ROOT_BITS (ROOT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_prod (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_len  (w_len),
        .o_area (o_surface_area)
    );

endmodule
